// File: hw/rtl/assert_macros.svh
// Assertion macros used by the checker file.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Property checked on every rising clock edge outside reset.
`define ASSERT_CLK(lbl, prop, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) prop) else $error(msg);

// Signal must hold its value in the cycle after cond.
`define ASSERT_HOLD(lbl, cond, sig, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) cond |=> $stable(sig)) \
		else $error(msg);

`endif

// File: hw/rtl/cgn_pkg.sv
// Types, constants and arithmetic helpers for the Canny gradient and NMS block.
package cgn_pkg;

	localparam int PIX_W = 12;
	localparam int DER_W = 27;
	localparam int ROW_W = 16;
	localparam int XW    = 10;
	localparam int PROD_W = 44;

	// round(2^31 / sqrt2)
	localparam logic [30:0] DIAG_MUL = 31'd1518500250;
	localparam logic [15:0] DIAG_RND = 16'd32768;

	localparam logic [1:0] REG_WIDTH  = 2'd0;
	localparam logic [1:0] REG_HEIGHT = 2'd1;
	localparam logic [1:0] REG_THRESH = 2'd2;

	typedef enum logic [1:0] {
		DIR_E  = 2'd0,
		DIR_NE = 2'd1,
		DIR_N  = 2'd2,
		DIR_SE = 2'd3
	} dir_t;

	typedef struct packed {
		dir_t             dir;
		logic [DER_W-1:0] val;
	} der_t;

	typedef struct packed {
		logic             vld;
		logic             interior;
		logic             emit;
		logic [ROW_W-1:0] y;
	} tag_t;

	function automatic logic [PIX_W-1:0] absdiff(input logic [PIX_W-1:0] a,
		input logic [PIX_W-1:0] b);
		return (a > b) ? (a - b) : (b - a);
	endfunction

	function automatic logic [DER_W-1:0] diag_scale(input logic [PIX_W-1:0] d);
		logic [PROD_W-1:0] p;
		p = PROD_W'(d) * PROD_W'(DIAG_MUL) + PROD_W'(DIAG_RND);
		return p[DER_W+15:16];
	endfunction

endpackage

// File: hw/rtl/cgn_ram.sv
// Generic simple dual-port RAM with registered read.
module cgn_ram #(
	parameter int W = 8,
	parameter int D = 16
) (
	input  logic                 clk,
	input  logic                 we,
	input  logic [$clog2(D)-1:0] waddr,
	input  logic [W-1:0]         wdata,
	input  logic                 re,
	input  logic [$clog2(D)-1:0] raddr,
	output logic [W-1:0]         rdata
);

	logic [W-1:0] mem_q [D];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem_q[raddr];
		end
	end

endmodule

// File: hw/rtl/cgn_grad.sv
// Pixel line buffers, 3x3 pixel window, directional derivatives and dominant direction.
module cgn_grad import cgn_pkg::*; #(
	parameter int MAX_WIDTH = 1024
) (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         en,
	input  tag_t                         tag_in,
	input  logic [$clog2(MAX_WIDTH)-1:0] col_in,
	input  logic [PIX_W-1:0]             pix_in,
	output tag_t                         tag_s1,
	output logic [$clog2(MAX_WIDTH)-1:0] col_s1,
	output tag_t                         tag_s2,
	output logic [$clog2(MAX_WIDTH)-1:0] col_s2,
	output der_t                         dom_s2
);

	localparam int AW = $clog2(MAX_WIDTH);

	logic [PIX_W-1:0] pix_s1;
	logic [PIX_W-1:0] row1_rd, row2_rd;
	logic [PIX_W-1:0] top1_q, mid1_q, bot1_q, top2_q, mid2_q, bot2_q;
	logic [DER_W-1:0] ge, gne, gn, gse;
	logic [DER_W-1:0] ge_s2, gne_s2, gn_s2, gse_s2;
	logic             wr_en;

	assign wr_en = en & tag_s1.vld;

	// row r-1
	cgn_ram #(.W(PIX_W), .D(MAX_WIDTH)) u_row1 (
		.clk  (clk),
		.we   (wr_en),
		.waddr(col_s1),
		.wdata(pix_s1),
		.re   (tag_in.vld),
		.raddr(col_in),
		.rdata(row1_rd)
	);

	// row r-2
	cgn_ram #(.W(PIX_W), .D(MAX_WIDTH)) u_row2 (
		.clk  (clk),
		.we   (wr_en),
		.waddr(col_s1),
		.wdata(row1_rd),
		.re   (tag_in.vld),
		.raddr(col_in),
		.rdata(row2_rd)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			tag_s1 <= '0;
			tag_s2 <= '0;
		end else if (en) begin
			tag_s1 <= tag_in;
			tag_s2 <= tag_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			col_s1 <= col_in;
			pix_s1 <= pix_in;
			col_s2 <= col_s1;
			ge_s2  <= ge;
			gne_s2 <= gne;
			gn_s2  <= gn;
			gse_s2 <= gse;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			top1_q <= '0;
			mid1_q <= '0;
			bot1_q <= '0;
			top2_q <= '0;
			mid2_q <= '0;
			bot2_q <= '0;
		end else if (wr_en) begin
			top1_q <= row2_rd;
			mid1_q <= row1_rd;
			bot1_q <= pix_s1;
			top2_q <= top1_q;
			mid2_q <= mid1_q;
			bot2_q <= bot1_q;
		end
	end

	always_comb begin
		ge  = {absdiff(row1_rd, mid2_q), 15'b0};
		gn  = {absdiff(top1_q, bot1_q), 15'b0};
		gne = diag_scale(absdiff(row2_rd, bot2_q));
		gse = diag_scale(absdiff(pix_s1, top2_q));
	end

	// ties go to the later direction
	always_comb begin
		if (ge_s2 > gne_s2 && ge_s2 > gn_s2 && ge_s2 > gse_s2) begin
			dom_s2.dir = DIR_E;
			dom_s2.val = ge_s2;
		end else if (gne_s2 > gn_s2 && gne_s2 > gse_s2) begin
			dom_s2.dir = DIR_NE;
			dom_s2.val = gne_s2;
		end else if (gn_s2 > gse_s2) begin
			dom_s2.dir = DIR_N;
			dom_s2.val = gn_s2;
		end else begin
			dom_s2.dir = DIR_SE;
			dom_s2.val = gse_s2;
		end
	end

	logic unused_aw;
	assign unused_aw = (AW > 0) ? 1'b0 : 1'b1;

endmodule

// File: hw/rtl/cgn_nms.sv
// Derivative line buffers, 3x3 derivative window, non-maximum suppression and output register.
module cgn_nms import cgn_pkg::*; #(
	parameter int MAX_WIDTH = 1024
) (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         en,
	input  tag_t                         tag_s1,
	input  logic [$clog2(MAX_WIDTH)-1:0] col_s1,
	input  tag_t                         tag_s2,
	input  logic [$clog2(MAX_WIDTH)-1:0] col_s2,
	input  der_t                         dom_s2,
	input  logic [DER_W-1:0]             thresh,
	output logic                         out_vld,
	output logic [XW-1:0]                out_x,
	output logic [ROW_W-1:0]             out_y,
	output logic                         out_above,
	output logic                         out_edge
);

	localparam int AW = $clog2(MAX_WIDTH);
	localparam int DW = $bits(der_t);

	logic [DW-1:0]  d1_rd, d2_rd;
	logic           wr_en;
	tag_t           tag_s3;
	logic [AW-1:0]  col_s3;
	der_t           top0_s3, mid0_s3, bot0_s3;
	der_t           top1_q, mid1_q, bot1_q, top2_q, mid2_q, bot2_q;
	der_t           fwd, back;
	logic           above, edge_hit;

	assign wr_en = en & tag_s2.vld & tag_s2.interior;

	// derivative row r-2
	cgn_ram #(.W(DW), .D(MAX_WIDTH)) u_der1 (
		.clk  (clk),
		.we   (wr_en),
		.waddr(col_s2 - AW'(1)),
		.wdata(dom_s2),
		.re   (en & tag_s1.vld),
		.raddr(col_s1 - AW'(1)),
		.rdata(d1_rd)
	);

	// derivative row r-3
	cgn_ram #(.W(DW), .D(MAX_WIDTH)) u_der2 (
		.clk  (clk),
		.we   (wr_en),
		.waddr(col_s2 - AW'(1)),
		.wdata(d1_rd),
		.re   (en & tag_s1.vld),
		.raddr(col_s1 - AW'(1)),
		.rdata(d2_rd)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			tag_s3  <= '0;
			out_vld <= 1'b0;
		end else if (en) begin
			tag_s3  <= tag_s2;
			out_vld <= tag_s3.vld & tag_s3.emit;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			col_s3    <= col_s2;
			bot0_s3   <= dom_s2;
			mid0_s3   <= der_t'(d1_rd);
			top0_s3   <= der_t'(d2_rd);
			out_x     <= XW'(col_s3 - AW'(2));
			out_y     <= tag_s3.y;
			out_above <= above;
			out_edge  <= edge_hit;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			top1_q <= '0;
			mid1_q <= '0;
			bot1_q <= '0;
			top2_q <= '0;
			mid2_q <= '0;
			bot2_q <= '0;
		end else if (en && tag_s3.vld) begin
			top1_q <= top0_s3;
			mid1_q <= mid0_s3;
			bot1_q <= bot0_s3;
			top2_q <= top1_q;
			mid2_q <= mid1_q;
			bot2_q <= bot1_q;
		end
	end

	// centre is mid1_q; top row is y-1, bottom row y+1
	always_comb begin
		case (mid1_q.dir)
			DIR_E: begin
				fwd  = mid0_s3;
				back = mid2_q;
			end
			DIR_NE: begin
				fwd  = top0_s3;
				back = bot2_q;
			end
			DIR_N: begin
				fwd  = top1_q;
				back = bot1_q;
			end
			DIR_SE: begin
				fwd  = bot0_s3;
				back = top2_q;
			end
			default: begin
				fwd  = mid0_s3;
				back = mid2_q;
			end
		endcase
		above    = mid1_q.val >= thresh;
		edge_hit = above && (mid1_q.val > fwd.val) && (mid1_q.val >= back.val);
	end

endmodule

// File: hw/rtl/canny_gradient_nms_discrete.sv
// Top level: configuration registers, raster position tracking and stream handshake.
// Takes one smoothed pixel per clock in raster order and returns, for every pixel at least
// two away from each border, its threshold and non-maximum-suppression edge flags. One pixel
// is accepted every cycle while the result register is free or being drained; a result passes
// s1, s2, s3 and output register after the pixel completing its 5x5 neighbourhood. Two pixel
// rows and two derivative rows sit in line buffers of MAX_WIDTH entries each; a frame_start
// pixel restarts the position at (0,0). Sizes are clamped to width 5..MAX_WIDTH, height >= 5.
module canny_gradient_nms_discrete import cgn_pkg::*; #(
	parameter int MAX_WIDTH = 1024
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        psel,
	input  logic        penable,
	input  logic        pwrite,
	input  logic [3:0]  paddr,
	input  logic [31:0] pwdata,
	output logic [31:0] prdata,
	output logic        pready,
	input  logic        s_axis_tvalid,
	output logic        s_axis_tready,
	input  logic [15:0] s_axis_tdata,  // [11:0] pixel
	input  logic        s_axis_tuser,  // frame_start
	output logic        m_axis_tvalid,
	input  logic        m_axis_tready,
	output logic [31:0] m_axis_tdata   // [9:0] out_x, [25:10] out_y, [26] above_threshold,
	                                   // [27] is_edge
);

	localparam int AW = $clog2(MAX_WIDTH);
	localparam int CW = $clog2(MAX_WIDTH + 1);

	logic [10:0]      image_width_q;
	logic [ROW_W-1:0] image_height_q;
	logic [DER_W-1:0] edge_threshold_q;
	logic [CW-1:0]    col_q;
	logic [ROW_W-1:0] row_q;

	logic [CW-1:0]    w_eff, col_base, c0;
	logic [ROW_W-1:0] h_eff;
	logic [ROW_W:0]   row_base, r0;
	logic             en, accept;
	tag_t             tag_in, tag_s1, tag_s2;
	logic [AW-1:0]    col_s1, col_s2;
	der_t             dom_s2;
	logic [XW-1:0]    out_x;
	logic [ROW_W-1:0] out_y;
	logic             out_above, out_edge;

	assign pready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			image_width_q    <= 11'd640;
			image_height_q   <= 16'd480;
			edge_threshold_q <= 27'd6291456;
		end else if (psel && penable && pwrite && pready) begin
			case (paddr[3:2])
				REG_WIDTH:  image_width_q    <= pwdata[10:0];
				REG_HEIGHT: image_height_q   <= pwdata[ROW_W-1:0];
				REG_THRESH: edge_threshold_q <= pwdata[DER_W-1:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		case (paddr[3:2])
			REG_WIDTH:  prdata = 32'(image_width_q);
			REG_HEIGHT: prdata = 32'(image_height_q);
			REG_THRESH: prdata = 32'(edge_threshold_q);
			default:    prdata = '0;
		endcase
	end

	always_comb begin
		if (image_width_q < 11'd5) begin
			w_eff = CW'(5);
		end else if (32'(image_width_q) > MAX_WIDTH) begin
			w_eff = CW'(MAX_WIDTH);
		end else begin
			w_eff = CW'(image_width_q);
		end
		h_eff = (image_height_q < 16'd5) ? 16'd5 : image_height_q;
	end

	always_comb begin
		col_base = s_axis_tuser ? '0 : col_q;
		row_base = s_axis_tuser ? '0 : {1'b0, row_q};
		if (col_base >= w_eff) begin
			c0 = '0;
			r0 = row_base + 17'd1;
		end else begin
			c0 = col_base;
			r0 = row_base;
		end
		if (r0 >= {1'b0, h_eff}) begin
			r0 = '0;
		end
	end

	assign en            = !m_axis_tvalid || m_axis_tready;
	assign s_axis_tready = en;
	assign accept        = s_axis_tvalid && s_axis_tready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			col_q <= '0;
			row_q <= '0;
		end else if (accept) begin
			col_q <= c0 + CW'(1);
			row_q <= r0[ROW_W-1:0];
		end
	end

	always_comb begin
		tag_in.vld      = accept;
		tag_in.interior = (c0 >= CW'(2)) && (r0 >= 17'd2);
		tag_in.emit     = (c0 >= CW'(4)) && (r0 >= 17'd4);
		tag_in.y        = r0[ROW_W-1:0] - 16'd2;
	end

	cgn_grad #(.MAX_WIDTH(MAX_WIDTH)) u_grad (
		.clk   (clk),
		.arst_n(arst_n),
		.en    (en),
		.tag_in(tag_in),
		.col_in(c0[AW-1:0]),
		.pix_in(s_axis_tdata[PIX_W-1:0]),
		.tag_s1(tag_s1),
		.col_s1(col_s1),
		.tag_s2(tag_s2),
		.col_s2(col_s2),
		.dom_s2(dom_s2)
	);

	cgn_nms #(.MAX_WIDTH(MAX_WIDTH)) u_nms (
		.clk      (clk),
		.arst_n   (arst_n),
		.en       (en),
		.tag_s1   (tag_s1),
		.col_s1   (col_s1),
		.tag_s2   (tag_s2),
		.col_s2   (col_s2),
		.dom_s2   (dom_s2),
		.thresh   (edge_threshold_q),
		.out_vld  (m_axis_tvalid),
		.out_x    (out_x),
		.out_y    (out_y),
		.out_above(out_above),
		.out_edge (out_edge)
	);

	assign m_axis_tdata = {4'b0, out_edge, out_above, out_y, out_x};

endmodule

// File: hw/rtl/cgn_chk.sv
// Port-level checker for the Canny gradient and NMS block, bound to the top level.
`include "assert_macros.svh"

module cgn_chk (
	input logic        clk,
	input logic        arst_n,
	input logic        s_axis_tvalid,
	input logic        s_axis_tready,
	input logic        m_axis_tvalid,
	input logic        m_axis_tready,
	input logic [31:0] m_axis_tdata
);

	`ASSERT_CLK(a_out_hold, m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid, "result dropped")
	`ASSERT_HOLD(a_data_hold, m_axis_tvalid && !m_axis_tready, m_axis_tdata, "result changed")
	`ASSERT_CLK(a_ready_free, !m_axis_tvalid |-> s_axis_tready, "input stalled with empty output")
	`ASSERT_CLK(a_edge_above, m_axis_tvalid |-> (!m_axis_tdata[27] || m_axis_tdata[26]), "edge below threshold")
	`ASSERT_CLK(a_interior, m_axis_tvalid |-> (m_axis_tdata[9:1] != 9'd0) && (m_axis_tdata[25:11] != 15'd0), "border pixel emitted")

	logic unused_tvalid;
	assign unused_tvalid = s_axis_tvalid;

endmodule

bind canny_gradient_nms_discrete cgn_chk u_chk (.*);
